@@ design/qrs_pkg.sv @@
// Package for the quadratic root solver: widths, mode codes and the sideband struct.
// It has no dependencies. Every module of the solver imports it.
`default_nettype none
package qrs_pkg;

  localparam int CW      = 32;              // coefficient width
  localparam int FB      = 16;              // fraction bits
  localparam int EPS_W   = 17;              // tolerance register width
  localparam int QB      = CW;              // quotient bits kept by a divider lane
  localparam int SQ_W    = CW + 1;          // square root width
  localparam int RAD_W   = 2 * CW + 1;      // radicand width
  localparam int SW      = 2 * SQ_W + 1;    // width of a trial square
  localparam int D_W     = 2 * CW + 2;      // signed discriminant width
  localparam int AB_W    = CW + 3;          // signed width of -c1 -/+ sqrt(d)
  localparam int NUM_W   = CW + 1;          // numerator magnitude width
  localparam int DEN_W   = CW + 1;          // denominator width
  localparam int N_W     = NUM_W + FB;      // shifted numerator width
  localparam int DV_W    = ((N_W > DEN_W + QB) ? N_W : DEN_W + QB) + 1;
  localparam int CMP_W   = (CW > EPS_W) ? CW : EPS_W;
  localparam int TH_W    = (D_W > EPS_W + FB) ? D_W : EPS_W + FB;
  localparam int DIV_LAT = QB + 2;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_LIN,
    MODE_DBL,
    MODE_TWO
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic            n0;
    logic            n1;
    logic            n2;
    logic [CW-1:0]   m0;
    logic [CW-1:0]   m1;
    logic [CW-1:0]   m2;
  } side_t;

endpackage
`default_nettype wire

@@ design/qrs_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a sideband carried along.
// Depends on qrs_pkg.
`default_nettype none
module qrs_sqrt (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [qrs_pkg::RAD_W-1:0] rad_i,
  input  wire qrs_pkg::side_t           side_i,
  output logic                          valid_o,
  output logic [qrs_pkg::SQ_W-1:0]      root_o,
  output qrs_pkg::side_t                side_o
);
  import qrs_pkg::*;

  logic [SQ_W-1:0]  r_q   [1:SQ_W];
  logic [SW-1:0]    r2_q  [1:SQ_W];
  logic [RAD_W-1:0] rad_q [1:SQ_W];
  side_t            side_q[1:SQ_W];
  logic [SQ_W:1]    valid_q;

  logic [SQ_W-1:0]  r_pr  [1:SQ_W];
  logic [SW-1:0]    r2_pr [1:SQ_W];
  logic [RAD_W-1:0] rad_pr[1:SQ_W];
  logic [SW-1:0]    cand  [1:SQ_W];
  logic [SQ_W-1:0]  r_d   [1:SQ_W];
  logic [SW-1:0]    r2_d  [1:SQ_W];

  // Stage k decides root bit SQ_W-k from the running square and the radicand.
  always_comb begin
    for (int k = 1; k <= SQ_W; k++) begin
      if (k == 1) begin
        r_pr[k]   = '0;
        r2_pr[k]  = '0;
        rad_pr[k] = rad_i;
      end else begin
        r_pr[k]   = r_q[k-1];
        r2_pr[k]  = r2_q[k-1];
        rad_pr[k] = rad_q[k-1];
      end
      cand[k] = r2_pr[k] + ({{(SW-SQ_W){1'b0}}, r_pr[k]} << (SQ_W - k + 1))
              + (SW'(1) << (2 * (SQ_W - k)));
      if (cand[k] <= {{(SW-RAD_W){1'b0}}, rad_pr[k]}) begin
        r_d[k]  = r_pr[k] | (SQ_W'(1) << (SQ_W - k));
        r2_d[k] = cand[k];
      end else begin
        r_d[k]  = r_pr[k];
        r2_d[k] = r2_pr[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[SQ_W-1:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 1; k <= SQ_W; k++) begin
        r_q[k]   <= r_d[k];
        r2_q[k]  <= r2_d[k];
        rad_q[k] <= rad_pr[k];
        if (k == 1) begin
          side_q[k] <= side_i;
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  assign valid_o = valid_q[SQ_W];
  assign root_o  = r_q[SQ_W];
  assign side_o  = side_q[SQ_W];

endmodule
`default_nettype wire

@@ design/qrs_div.sv @@
// Pipelined restoring divider lane: signed, truncated and saturated Q-format quotient.
// One quotient bit per stage after an overflow pre-check. Depends on qrs_pkg.
`default_nettype none
module qrs_div (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [qrs_pkg::NUM_W-1:0] num_i,
  input  wire logic [qrs_pkg::DEN_W-1:0] den_i,
  input  wire logic                     neg_i,
  output logic [qrs_pkg::CW-1:0]        root_o,
  output logic                          sat_o
);
  import qrs_pkg::*;

  logic [DV_W-1:0]  rem_q [0:QB];
  logic [DEN_W-1:0] den_q [0:QB];
  logic [QB-1:0]    quo_q [0:QB];
  logic [QB:0]      ovf_q;
  logic [QB:0]      neg_q;
  logic [DV_W-1:0]  rem_d [1:QB];
  logic [QB-1:0]    quo_d [1:QB];
  logic [DV_W-1:0]  shd   [1:QB];

  logic [DV_W-1:0]  num_ext;
  logic [DV_W-1:0]  den_top;
  logic [QB-1:0]    lim;
  logic             sat_d;
  logic [QB-1:0]    qs;
  logic [CW-1:0]    root_q;
  logic             sat_q;

  // The quotient fits in QB bits exactly when the numerator is below den << QB.
  assign num_ext = {{(DV_W-N_W){1'b0}}, num_i, {FB{1'b0}}};
  assign den_top = {{(DV_W-DEN_W){1'b0}}, den_i} << QB;

  always_comb begin
    for (int j = 1; j <= QB; j++) begin
      shd[j] = {{(DV_W-DEN_W){1'b0}}, den_q[j-1]} << (QB - j);
      if (rem_q[j-1] >= shd[j]) begin
        rem_d[j] = rem_q[j-1] - shd[j];
        quo_d[j] = quo_q[j-1] | (QB'(1) << (QB - j));
      end else begin
        rem_d[j] = rem_q[j-1];
        quo_d[j] = quo_q[j-1];
      end
    end
  end

  // Negative results may reach one step further than positive ones.
  assign lim   = {1'b0, {(QB-1){1'b1}}} + QB'(neg_q[QB]);
  assign sat_d = ovf_q[QB] || (quo_q[QB] > lim);
  assign qs    = sat_d ? lim : quo_q[QB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_ext;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (num_ext >= den_top);
      neg_q[0] <= neg_i;
      for (int j = 1; j <= QB; j++) begin
        rem_q[j] <= rem_d[j];
        den_q[j] <= den_q[j-1];
        quo_q[j] <= quo_d[j];
        ovf_q[j] <= ovf_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
      root_q <= neg_q[QB] ? CW'(~qs + QB'(1)) : CW'(qs);
      sat_q  <= sat_d;
    end
  end

  assign root_o = root_q;
  assign sat_o  = sat_q;

endmodule
`default_nettype wire

@@ design/quadratic_root_solver_unit.sv @@
// Quadratic root solver top level: real roots of c2*x^2 + c1*x + c0 in signed Q16.16.
// Throughput is one item per cycle while no finished result waits at the output.
// The depth is set by the square root (33 stages) and the dividers (34 stages).
// The whole pipeline holds while a finished result waits at the output.
// Reset clears every valid bit and sets root_eps to 1; there is no clearing pass.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
`default_nettype none
module quadratic_root_solver_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [qrs_pkg::EPS_W-1:0]  root_eps_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [qrs_pkg::CW-1:0] coef_const_i,
  input  wire logic signed [qrs_pkg::CW-1:0] coef_lin_i,
  input  wire logic signed [qrs_pkg::CW-1:0] coef_quad_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [qrs_pkg::CW-1:0]   root_first_o,
  output logic signed [qrs_pkg::CW-1:0]   root_second_o,
  output logic [1:0]                      root_count_o,
  output logic                            saturated_o
);
  import qrs_pkg::*;

  // The user must write the tolerance register only while the pipeline is empty (the block
  // does not enforce it), so every stage may read it directly.
  logic [EPS_W-1:0] eps_q;
  logic             en;

  // Stage 1: magnitudes and signs of the coefficients.
  logic             v1_q;
  logic [CW-1:0]    m0_q1, m1_q1, m2_q1;
  logic             n0_q1, n1_q1, n2_q1;

  // Stage 2: products and the linear-case decision.
  logic             v2_q;
  logic [2*CW-1:0]  p11_q2, p02_q2;
  logic [CW-1:0]    m0_q2, m1_q2, m2_q2;
  logic             n0_q2, n1_q2, n2_q2;
  logic             lin_q2, linok_q2;

  // Stage 3: the exact discriminant.
  logic             v3_q;
  logic signed [D_W-1:0] d_q3;
  logic [CW-1:0]    m0_q3, m1_q3, m2_q3;
  logic             n0_q3, n1_q3, n2_q3;
  logic             lin_q3, linok_q3;
  logic signed [D_W-1:0] d_d3;
  logic [D_W-1:0]   sq_ext, p4_ext;

  // Stage 4: classification and the radicand for the square root.
  logic             v4_q;
  logic [RAD_W-1:0] rad_q4;
  side_t            side_q4;
  logic [D_W-1:0]   dmag;
  logic             zd;
  mode_e            mode_d4;

  // Square root output.
  logic             vs;
  logic [SQ_W-1:0]  sroot;
  side_t            sside;

  // Stage 5: numerators, denominators and signs for the two divider lanes.
  logic             v5_q;
  mode_e            mode_q5;
  logic [NUM_W-1:0] num0_q5, num1_q5;
  logic [DEN_W-1:0] den0_q5, den1_q5;
  logic             neg0_q5, neg1_q5;
  logic signed [AB_W-1:0] mc1, sx, a_v, b_v;
  logic [AB_W-1:0]  ma_w, mb_w;
  logic             na, nb;
  logic [NUM_W-1:0] ma, mb;
  logic [DEN_W-1:0] den2;
  logic [NUM_W-1:0] num0_d, num1_d;
  logic [DEN_W-1:0] den0_d, den1_d;
  logic             neg0_d, neg1_d;

  // Result side: a valid and mode line that runs beside the dividers.
  logic [DIV_LAT-1:0] vline_q;
  mode_e            mline_q [0:DIV_LAT-1];
  mode_e            mode_out;
  logic [CW-1:0]    q0, q1;
  logic             sat0, sat1;

  logic [CW-1:0]    m0_c, m1_c, m2_c;

  // A result that waits holds every stage; otherwise the pipeline moves each cycle.
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_W'(1);
    end else if (cfg_valid_i) begin
      eps_q <= root_eps_i;
    end
  end

  assign m0_c = coef_const_i[CW-1] ? CW'(~coef_const_i + CW'(1)) : CW'(coef_const_i);
  assign m1_c = coef_lin_i[CW-1]   ? CW'(~coef_lin_i + CW'(1))   : CW'(coef_lin_i);
  assign m2_c = coef_quad_i[CW-1]  ? CW'(~coef_quad_i + CW'(1))  : CW'(coef_quad_i);

  // Stage 3 logic: d = c1^2 - 4*c0*c2, built from magnitudes and signs.
  assign sq_ext = {{(D_W-2*CW){1'b0}}, p11_q2};
  assign p4_ext = {{(D_W-2*CW){1'b0}}, p02_q2} << 2;
  assign d_d3   = (n0_q2 != n2_q2) ? $signed(sq_ext + p4_ext) : $signed(sq_ext - p4_ext);

  // Stage 4 logic: a discriminant within the scaled tolerance counts as zero.
  assign dmag = d_q3[D_W-1] ? D_W'(~d_q3 + D_W'(1)) : D_W'(d_q3);
  assign zd   = {{(TH_W-D_W){1'b0}}, dmag}
             <= {{(TH_W-EPS_W-FB){1'b0}}, eps_q, {FB{1'b0}}};

  always_comb begin
    if (lin_q3) begin
      mode_d4 = linok_q3 ? MODE_LIN : MODE_NONE;
    end else if (zd) begin
      mode_d4 = MODE_DBL;
    end else if (d_q3[D_W-1]) begin
      mode_d4 = MODE_NONE;
    end else begin
      mode_d4 = MODE_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_q1    <= m0_c;
      m1_q1    <= m1_c;
      m2_q1    <= m2_c;
      n0_q1    <= coef_const_i[CW-1];
      n1_q1    <= coef_lin_i[CW-1];
      n2_q1    <= coef_quad_i[CW-1];

      p11_q2   <= m1_q1 * m1_q1;
      p02_q2   <= m0_q1 * m2_q1;
      m0_q2    <= m0_q1;
      m1_q2    <= m1_q1;
      m2_q2    <= m2_q1;
      n0_q2    <= n0_q1;
      n1_q2    <= n1_q1;
      n2_q2    <= n2_q1;
      lin_q2   <= {{(CMP_W-CW){1'b0}}, m2_q1} <= {{(CMP_W-EPS_W){1'b0}}, eps_q};
      linok_q2 <= ({{(CMP_W-CW){1'b0}}, m1_q1} >= {{(CMP_W-EPS_W){1'b0}}, eps_q})
               && (m1_q1 != '0);

      d_q3     <= d_d3;
      m0_q3    <= m0_q2;
      m1_q3    <= m1_q2;
      m2_q3    <= m2_q2;
      n0_q3    <= n0_q2;
      n1_q3    <= n1_q2;
      n2_q3    <= n2_q2;
      lin_q3   <= lin_q2;
      linok_q3 <= linok_q2;

      rad_q4       <= (mode_d4 == MODE_TWO) ? RAD_W'(d_q3) : '0;
      side_q4.mode <= mode_d4;
      side_q4.n0   <= n0_q3;
      side_q4.n1   <= n1_q3;
      side_q4.n2   <= n2_q3;
      side_q4.m0   <= m0_q3;
      side_q4.m1   <= m1_q3;
      side_q4.m2   <= m2_q3;
    end
  end

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .rad_i   (rad_q4),
    .side_i  (side_q4),
    .valid_o (vs),
    .root_o  (sroot),
    .side_o  (sside)
  );

  // Stage 5 logic: -c1 -/+ sqrt(d) as magnitude and sign, then lane selection.
  assign mc1  = sside.n1 ? $signed({{(AB_W-CW){1'b0}}, sside.m1})
                         : -$signed({{(AB_W-CW){1'b0}}, sside.m1});
  assign sx   = $signed({{(AB_W-SQ_W){1'b0}}, sroot});
  assign a_v  = mc1 - sx;
  assign b_v  = mc1 + sx;
  assign na   = a_v[AB_W-1];
  assign nb   = b_v[AB_W-1];
  assign ma_w = na ? AB_W'(-a_v) : AB_W'(a_v);
  assign mb_w = nb ? AB_W'(-b_v) : AB_W'(b_v);
  assign ma   = ma_w[NUM_W-1:0];
  assign mb   = mb_w[NUM_W-1:0];
  assign den2 = {sside.m2, 1'b0};

  always_comb begin
    num0_d = '0;
    den0_d = '0;
    neg0_d = 1'b0;
    num1_d = '0;
    den1_d = '0;
    neg1_d = 1'b0;
    case (sside.mode)
      MODE_LIN: begin
        num0_d = {1'b0, sside.m0};
        den0_d = {1'b0, sside.m1};
        neg0_d = (sside.m0 != '0) && (sside.n0 == sside.n1);
      end
      MODE_DBL: begin
        num0_d = {1'b0, sside.m1};
        den0_d = den2;
        neg0_d = (sside.m1 != '0) && (sside.n1 == sside.n2);
      end
      MODE_TWO: begin
        num0_d = ma;
        den0_d = den2;
        neg0_d = (ma != '0) && (na != sside.n2);
        num1_d = mb;
        den1_d = den2;
        neg1_d = (mb != '0) && (nb != sside.n2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_q5 <= sside.mode;
      num0_q5 <= num0_d;
      den0_q5 <= den0_d;
      neg0_q5 <= neg0_d;
      num1_q5 <= num1_d;
      den1_q5 <= den1_d;
      neg1_q5 <= neg1_d;
    end
  end

  qrs_div u_div_first (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (num0_q5),
    .den_i  (den0_q5),
    .neg_i  (neg0_q5),
    .root_o (q0),
    .sat_o  (sat0)
  );

  qrs_div u_div_second (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (num1_q5),
    .den_i  (den1_q5),
    .neg_i  (neg1_q5),
    .root_o (q1),
    .sat_o  (sat1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vline_q <= '0;
    end else if (en) begin
      vline_q <= {vline_q[DIV_LAT-2:0], v5_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mline_q[0] <= mode_q5;
      for (int j = 1; j < DIV_LAT; j++) begin
        mline_q[j] <= mline_q[j-1];
      end
    end
  end

  assign mode_out    = mline_q[DIV_LAT-1];
  assign out_valid_o = vline_q[DIV_LAT-1];

  // A lane only counts towards the flag when its root is reported.
  always_comb begin
    case (mode_out)
      MODE_LIN: begin
        root_first_o  = q0;
        root_second_o = '0;
        root_count_o  = 2'd1;
        saturated_o   = sat0;
      end
      MODE_DBL: begin
        root_first_o  = q0;
        root_second_o = q0;
        root_count_o  = 2'd1;
        saturated_o   = sat0;
      end
      MODE_TWO: begin
        root_first_o  = q0;
        root_second_o = q1;
        root_count_o  = 2'd2;
        saturated_o   = sat0 || sat1;
      end
      default: begin
        root_first_o  = '0;
        root_second_o = '0;
        root_count_o  = 2'd0;
        saturated_o   = 1'b0;
      end
    endcase
  end

  // An accepted item always shows up in the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted item did not enter the pipeline");

  // A held pipeline keeps its first-stage and stage-5 valid bits.
  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(v5_q))
    else $error("stalled pipeline changed its valid bits");

  // A linear root never reports a second root.
  a_lin_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_out == MODE_LIN |-> root_second_o == '0)
    else $error("linear result carries a second root");

  // A double root reports the same value twice.
  a_dbl_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_out == MODE_DBL |-> root_first_o == root_second_o)
    else $error("double root differs between outputs");

endmodule
`default_nettype wire
